### hdl/nlp_pkg.sv
package nlp_pkg;

  // literal formats as reported on the result
  localparam logic [1:0] FMT_DEC = 2'd0;
  localparam logic [1:0] FMT_HEX = 2'd1;
  localparam logic [1:0] FMT_BIN = 2'd2;
  localparam logic [1:0] FMT_UNK = 2'd3;

  // range modes
  localparam logic [1:0] MODE_U8  = 2'd0;
  localparam logic [1:0] MODE_U16 = 2'd1;
  localparam logic [1:0] MODE_S16 = 2'd2;
  localparam logic [1:0] MODE_RAW = 2'd3;

  // accumulation limits and range bounds
  localparam logic [35:0] LIMIT_16  = 36'h0_0000_FFFF;
  localparam logic [35:0] LIMIT_32  = 36'h0_FFFF_FFFF;
  localparam logic [35:0] MAX_U8    = 36'h0_0000_00FF;
  localparam logic [35:0] MAX_U16   = 36'h0_0000_FFFF;
  localparam logic [35:0] MAX_S16   = 36'h0_0000_7FFF;
  localparam logic [35:0] MAX_NEG16 = 36'h0_0000_8000;

  // characters of interest
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] HEX_UP_OFS = 8'd55;
  localparam logic [7:0] HEX_LO_OFS = 8'd87;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } lit_in_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        parse_error;
    logic [1:0]  literal_format;
  } lit_out_t;

  // decoded character as it travels between front and back
  typedef struct packed {
    logic       is_dec;
    logic       is_bin;
    logic       hex_ok;
    logic [3:0] nibble;
    logic       is_zero;
    logic       is_x;
    logic       is_b;
    logic       is_minus;
    logic       last;
  } char_class_t;

  // what the back part keeps of the first character
  typedef struct packed {
    logic is_zero;
    logic is_b;
    logic is_minus;
    logic is_dec;
  } first_class_t;

  // finished literal handed to the result stage
  typedef struct packed {
    logic [35:0] acc;
    logic [1:0]  fmt;
    logic        neg;
    logic        err;
    logic        limit;
    logic        hex_odd;
  } fin_rec_t;

endpackage

### hdl/numeric_literal_parser_unit.sv
// numeric literal parser: decimal, 0x hex and b-prefixed binary integers
// input side is a queue: drive push with one character beat on literal_char
// (char_in plus last_char on the final character); the beat is taken at an
// edge where push is high and full is low
// result side is a queue too: while empty is low the oldest result sits on
// parse_result (value, error flag, format); pop at an edge with empty low takes it
// one result per literal, produced by the beat marked last_char
// throughput: one character per cycle when not stalled, no gaps between literals
// a last character's result passes the decode queue, then the accumulate stage,
// then the range check into the result queue
// for decimal digits the accumulate stage does a times-ten add and one limit
// compare per beat; when pop stays low the result queue fills, the back part then
// holds and the input queue fills in turn, so full rises; nothing is dropped
// range_mode is written with cfg_wr_en/cfg_wr_data; the user must write it only
// while nothing is in flight, the block does not enforce it; reset clears both
// queues, all literal state and range_mode to uint8
module numeric_literal_parser_unit
  import nlp_pkg::*;
  #(
    parameter int MAX_DEC_DIGITS = 19,
    parameter int MAX_HEX_DIGITS = 8,
    parameter int MAX_BIN_DIGITS = 64
  )
  (
    input  logic       clk,
    input  logic       rst,
    input  logic       push,
    output logic       full,
    input  lit_in_t    literal_char,
    output logic       empty,
    input  logic       pop,
    output lit_out_t   parse_result,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data
  );

  logic [1:0]  range_mode_q;
  logic        q_pop;
  logic        q_empty;
  char_class_t q_item;
  logic        fin_valid;
  logic        fin_take;
  fin_rec_t    fin_rec;

  // range mode register, to be written only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      range_mode_q <= MODE_U8;
    end else if (cfg_wr_en) begin
      range_mode_q <= cfg_wr_data;
    end
  end

  // front: character decode and the decoupling queue
  nlp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .literal_char (literal_char),
    .q_pop        (q_pop),
    .q_empty      (q_empty),
    .q_item       (q_item)
  );

  // back: format tracking and value accumulation, one beat per cycle when not stalled
  nlp_exec #(
    .MAX_DEC_DIGITS (MAX_DEC_DIGITS),
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS),
    .MAX_BIN_DIGITS (MAX_BIN_DIGITS)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .range_mode (range_mode_q),
    .q_empty    (q_empty),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .fin_valid  (fin_valid),
    .fin_take   (fin_take),
    .fin_rec    (fin_rec)
  );

  // range check, sign and result queue
  nlp_result u_result (
    .clk          (clk),
    .rst          (rst),
    .range_mode   (range_mode_q),
    .fin_valid    (fin_valid),
    .fin_rec      (fin_rec),
    .fin_take     (fin_take),
    .empty        (empty),
    .pop          (pop),
    .parse_result (parse_result)
  );

endmodule

### hdl/nlp_fifo.sv
module nlp_fifo
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
  )
  (
    input  logic             clk,
    input  logic             rst,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
  );

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

### hdl/nlp_front.sv
module nlp_front
  import nlp_pkg::*;
  (
    input  logic        clk,
    input  logic        rst,
    input  logic        push,
    output logic        full,
    input  lit_in_t     literal_char,
    input  logic        q_pop,
    output logic        q_empty,
    output char_class_t q_item
  );

  char_class_t cls;
  logic [7:0]  c;
  logic [$bits(char_class_t)-1:0] q_raw;

  assign c = literal_char.char_in;

  always_comb begin
    cls          = '0;
    cls.is_dec   = (c inside {[CH_ZERO:CH_NINE]});
    cls.is_bin   = (c == CH_ZERO) || (c == CH_ONE);
    cls.is_zero  = (c == CH_ZERO);
    cls.is_x     = (c == CH_X);
    cls.is_b     = (c == CH_B);
    cls.is_minus = (c == CH_MINUS);
    cls.last     = literal_char.last_char;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      cls.hex_ok = 1'b1;
      cls.nibble = 4'(c - CH_ZERO);
    end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
      cls.hex_ok = 1'b1;
      cls.nibble = 4'(c - HEX_UP_OFS);
    end else if (c inside {[CH_LO_A:CH_LO_F]}) begin
      cls.hex_ok = 1'b1;
      cls.nibble = 4'(c - HEX_LO_OFS);
    end
  end

  // decoded beats wait here until the back part takes them
  nlp_fifo #(
    .WIDTH ($bits(char_class_t)),
    .DEPTH (2)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cls),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_raw),
    .empty   (q_empty)
  );

  assign q_item = char_class_t'(q_raw);

endmodule

### hdl/nlp_exec.sv
module nlp_exec
  import nlp_pkg::*;
  #(
    parameter int MAX_DEC_DIGITS = 19,
    parameter int MAX_HEX_DIGITS = 8,
    parameter int MAX_BIN_DIGITS = 64
  )
  (
    input  logic        clk,
    input  logic        rst,
    input  logic [1:0]  range_mode,
    input  logic        q_empty,
    input  char_class_t q_item,
    output logic        q_pop,
    output logic        fin_valid,
    input  logic        fin_take,
    output fin_rec_t    fin_rec
  );

  logic [6:0]   position;
  first_class_t first_cls;
  logic [1:0]   format_kind;
  logic [35:0]  accumulator;
  logic         negative_flag;
  logic         error_flag;
  logic         limit_reached;
  logic [3:0]   pending_nibble;

  logic [6:0]   position_next;
  first_class_t first_cls_next;
  logic [1:0]   format_kind_next;
  logic [35:0]  accumulator_next;
  logic         negative_flag_next;
  logic         error_flag_next;
  logic         limit_reached_next;
  logic [3:0]   pending_nibble_next;

  logic         do_dec;
  logic         do_bin;
  logic         do_hex;
  logic [6:0]   dec_idx;
  logic [6:0]   bin_idx;
  logic [6:0]   hex_idx;
  logic [6:0]   hex_cnt;
  logic [35:0]  limit;
  logic [35:0]  dec_acc;
  logic [35:0]  bin_acc;
  logic [35:0]  hex_acc;
  logic         advance;

  assign advance = !q_empty && !(fin_valid && !fin_take);
  assign q_pop   = advance;

  assign limit   = (range_mode == MODE_RAW) ? LIMIT_32 : LIMIT_16;
  assign dec_acc = (accumulator << 3) + (accumulator << 1) + 36'(q_item.nibble);
  assign bin_acc = {accumulator[34:0], q_item.is_zero ? 1'b0 : 1'b1};
  assign hex_acc = {4'd0, accumulator[23:0], pending_nibble, q_item.nibble};
  assign bin_idx = position - 7'd1;
  assign hex_idx = position - 7'd2;

  always_comb begin
    first_cls_next      = first_cls;
    format_kind_next    = format_kind;
    accumulator_next    = accumulator;
    negative_flag_next  = negative_flag;
    error_flag_next     = error_flag;
    limit_reached_next  = limit_reached;
    pending_nibble_next = pending_nibble;
    do_dec              = 1'b0;
    do_bin              = 1'b0;
    do_hex              = 1'b0;
    dec_idx             = position - 7'(negative_flag);

    // format is decided on the first two characters
    if (position == 7'd0) begin
      first_cls_next = '{is_zero: q_item.is_zero, is_b: q_item.is_b,
                         is_minus: q_item.is_minus, is_dec: q_item.is_dec};
      if (q_item.is_dec) begin
        format_kind_next = FMT_DEC;
        do_dec           = 1'b1;
      end else begin
        format_kind_next = FMT_UNK;
      end
    end else if (position == 7'd1) begin
      if (first_cls.is_zero) begin
        format_kind_next = q_item.is_x ? FMT_HEX : FMT_UNK;
      end else if (first_cls.is_b) begin
        if (q_item.is_bin) begin
          format_kind_next = FMT_BIN;
          do_bin           = 1'b1;
        end else begin
          format_kind_next = FMT_UNK;
        end
      end else if (first_cls.is_minus) begin
        if (q_item.is_dec) begin
          format_kind_next   = FMT_DEC;
          negative_flag_next = 1'b1;
          do_dec             = 1'b1;
          dec_idx            = 7'd0;
        end else begin
          format_kind_next = FMT_UNK;
        end
      end else if (first_cls.is_dec) begin
        do_dec = 1'b1;
      end else begin
        format_kind_next = FMT_UNK;
      end
    end else begin
      case (format_kind)
        FMT_DEC: do_dec = 1'b1;
        FMT_HEX: do_hex = 1'b1;
        FMT_BIN: do_bin = 1'b1;
        default: ;
      endcase
    end

    if (do_dec && (dec_idx < 7'(MAX_DEC_DIGITS)) && !limit_reached) begin
      if (!q_item.is_dec) begin
        error_flag_next = 1'b1;
      end else begin
        accumulator_next = dec_acc;
        if (dec_acc > limit) begin
          limit_reached_next = 1'b1;
        end
      end
    end

    if (do_bin && (bin_idx < 7'(MAX_BIN_DIGITS)) && !limit_reached) begin
      if (!q_item.is_bin) begin
        error_flag_next = 1'b1;
      end else begin
        accumulator_next = bin_acc;
        if (bin_acc > limit) begin
          limit_reached_next = 1'b1;
        end
      end
    end

    // hex digits are taken in pairs, the first one waits as a pending nibble
    if (do_hex && (hex_idx < 7'(MAX_HEX_DIGITS))) begin
      if (!q_item.hex_ok) begin
        error_flag_next     = 1'b1;
        pending_nibble_next = 4'd0;
      end else if (!hex_idx[0]) begin
        pending_nibble_next = q_item.nibble;
      end else begin
        if (accumulator[35:24] != 12'd0) begin
          limit_reached_next = 1'b1;
        end
        accumulator_next    = hex_acc;
        pending_nibble_next = 4'd0;
      end
    end
  end

  assign position_next = (position == 7'd127) ? position : position + 7'd1;
  assign hex_cnt       = position_next - 7'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      first_cls      <= '0;
      format_kind    <= FMT_DEC;
      accumulator    <= '0;
      negative_flag  <= 1'b0;
      error_flag     <= 1'b0;
      limit_reached  <= 1'b0;
      pending_nibble <= '0;
      fin_valid      <= 1'b0;
    end else begin
      if (advance && q_item.last) begin
        fin_valid <= 1'b1;
      end else if (fin_take) begin
        fin_valid <= 1'b0;
      end
      if (advance) begin
        if (q_item.last) begin
          position       <= '0;
          first_cls      <= '0;
          format_kind    <= FMT_DEC;
          accumulator    <= '0;
          negative_flag  <= 1'b0;
          error_flag     <= 1'b0;
          limit_reached  <= 1'b0;
          pending_nibble <= '0;
        end else begin
          position       <= position_next;
          first_cls      <= first_cls_next;
          format_kind    <= format_kind_next;
          accumulator    <= accumulator_next;
          negative_flag  <= negative_flag_next;
          error_flag     <= error_flag_next;
          limit_reached  <= limit_reached_next;
          pending_nibble <= pending_nibble_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_item.last) begin
      fin_rec.acc     <= accumulator_next;
      fin_rec.fmt     <= format_kind_next;
      fin_rec.neg     <= negative_flag_next;
      fin_rec.err     <= error_flag_next;
      fin_rec.limit   <= limit_reached_next;
      fin_rec.hex_odd <= (hex_cnt > 7'(MAX_HEX_DIGITS)) ? MAX_HEX_DIGITS[0] : hex_cnt[0];
    end
  end

endmodule

### hdl/nlp_result.sv
module nlp_result
  import nlp_pkg::*;
  (
    input  logic      clk,
    input  logic      rst,
    input  logic [1:0] range_mode,
    input  logic      fin_valid,
    input  fin_rec_t  fin_rec,
    output logic      fin_take,
    output logic      empty,
    input  logic      pop,
    output lit_out_t  parse_result
  );

  lit_out_t res;
  logic     out_full;
  logic     neg;
  logic     big;
  logic     err;
  logic [$bits(lit_out_t)-1:0] out_raw;

  assign fin_take = fin_valid && !out_full;

  always_comb begin
    neg = fin_rec.neg && (fin_rec.fmt == FMT_DEC);
    big = (fin_rec.fmt == FMT_HEX) && fin_rec.limit;
    err = fin_rec.err || (fin_rec.fmt == FMT_UNK) ||
          ((fin_rec.fmt == FMT_HEX) && fin_rec.hex_odd);
    case (range_mode)
      MODE_U8: begin
        if ((neg && fin_rec.acc != '0) || big || fin_rec.acc > MAX_U8) err = 1'b1;
      end
      MODE_U16: begin
        if ((neg && fin_rec.acc != '0) || big || fin_rec.acc > MAX_U16) err = 1'b1;
      end
      MODE_S16: begin
        if (big || (neg ? (fin_rec.acc > MAX_NEG16) : (fin_rec.acc > MAX_S16))) err = 1'b1;
      end
      default: ;
    endcase
    res.result_value   = err ? 32'd0 :
                         (neg ? (32'd0 - fin_rec.acc[31:0]) : fin_rec.acc[31:0]);
    res.parse_error    = err;
    res.literal_format = fin_rec.fmt;
  end

  nlp_fifo #(
    .WIDTH ($bits(lit_out_t)),
    .DEPTH (2)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fin_take),
    .wr_data (res),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_raw),
    .empty   (empty)
  );

  assign parse_result = lit_out_t'(out_raw);

endmodule
